// ===== sv/led_color_smooth_gamma_defines.svh =====
// Assertion macros shared by the checker of led_color_smooth_gamma.
// Stand-alone header; needs no other file.
`ifndef LED_COLOR_SMOOTH_GAMMA_DEFINES_SVH
`define LED_COLOR_SMOOTH_GAMMA_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LCSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcsg check failed");

// next-cycle implication, quiet during reset
`define LCSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcsg check failed");

`endif

// ===== sv/lcsg_pkg.sv =====
// Shared types and constants of the LED color smoothing / gamma block.
// No dependencies.
package lcsg_pkg;

   localparam int LED_COUNT = 256;
   localparam int CHANNELS  = LED_COUNT * 3;
   localparam int CHAN_W    = 10;
   localparam int LVL_AW    = $clog2(CHANNELS);
   localparam int GAM_AW    = 8;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 24;
   localparam int CSR_AW    = 1;
   localparam int CSR_DW    = 9;
   localparam int QUEUE_AW  = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

   localparam logic [CHAN_W-1:0] CHANNEL_COUNT = CHAN_W'(CHANNELS);
   localparam logic [LVL_AW-1:0] LAST_CHANNEL  = LVL_AW'(CHANNELS - 1);
   localparam logic [15:0] LEVEL_MAX    = 16'hFF00;
   localparam logic [8:0]  Q08_ONE      = 9'd256;
   localparam logic [8:0]  WEIGHT_RESET = 9'd64;
   localparam logic [8:0]  BRIGHT_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_SMOOTH = 2'd0,
      OP_SET    = 2'd1,
      OP_READ   = 2'd2,
      OP_GAMMA  = 2'd3
   } op_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_WEIGHT = 1'b0,
      CSR_BRIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type            op;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        value;
      logic [7:0]        lut_address;
      logic [15:0]       lut_word;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

endpackage

// ===== sv/lcsg_front.sv =====
// Front end: takes request items, drops out-of-range channel ops, queues the rest.
// Depends on lcsg_pkg.
module lcsg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // op[1:0], channel[11:2], value[19:12], lut_address[27:20], lut_word[43:28]
   input  logic [lcsg_pkg::REQ_W-1:0]    req_tdata,
   input  logic                          clear_busy,
   input  logic                          pop,
   output lcsg_pkg::queue_type           q
);

   lcsg_pkg::cmd_type                   cmd;
   lcsg_pkg::cmd_type                   fifo_ff [lcsg_pkg::QUEUE_DEPTH];
   logic [lcsg_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lcsg_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lcsg_pkg::QUEUE_AW:0]         count_ff, count_in;
   logic                                keep;
   logic                                push;

   assign cmd.op          = lcsg_pkg::op_type'(req_tdata[1:0]);
   assign cmd.channel     = req_tdata[11:2];
   assign cmd.value       = req_tdata[19:12];
   assign cmd.lut_address = req_tdata[27:20];
   assign cmd.lut_word    = req_tdata[43:28];

   assign keep       = (cmd.op == lcsg_pkg::OP_GAMMA) ||
                       (cmd.channel < lcsg_pkg::CHANNEL_COUNT);
   assign req_tready = (count_ff != (lcsg_pkg::QUEUE_AW+1)'(lcsg_pkg::QUEUE_DEPTH)) &&
                       !clear_busy;
   assign push       = req_tvalid && req_tready && keep;

   assign q.valid = (count_ff != '0);
   assign q.cmd   = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (lcsg_pkg::QUEUE_AW)'(push);
      rd_ptr_in = rd_ptr_ff + (lcsg_pkg::QUEUE_AW)'(pop);
      count_in  = count_ff + (lcsg_pkg::QUEUE_AW+1)'(push) -
                  (lcsg_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== sv/lcsg_back.sv =====
// Back end: level store, gamma table, smoothing update and output scaling.
// Depends on lcsg_pkg.
module lcsg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lcsg_pkg::CSR_AW-1:0]   csr_index,
   input  logic [lcsg_pkg::CSR_DW-1:0]   csr_wdata,
   input  lcsg_pkg::queue_type           q,
   output logic                          pop,
   output logic                          clear_busy,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [lcsg_pkg::CHAN_W-1:0]   rsp_channel,
   output logic [7:0]                    rsp_level
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   state_type                        state_ff, state_in;
   logic                             clear_ff, clear_in;
   logic [lcsg_pkg::LVL_AW-1:0]      clr_cnt_ff, clr_cnt_in;
   lcsg_pkg::cmd_type                cur_ff, cur_in;
   logic [8:0]                       weight_ff, weight_in;
   logic [8:0]                       bright_ff, bright_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lcsg_pkg::CHAN_W-1:0]      rsp_channel_ff, rsp_channel_in;
   logic [7:0]                       rsp_level_ff, rsp_level_in;

   logic [15:0]                      lvl_mem [lcsg_pkg::CHANNELS];
   logic [15:0]                      gam_mem [2 ** lcsg_pkg::GAM_AW];
   logic [15:0]                      lvl_rd_ff;
   logic [15:0]                      gam_rd_ff;

   logic                             lvl_we;
   logic [lcsg_pkg::LVL_AW-1:0]      lvl_waddr;
   logic [15:0]                      lvl_wdata;
   logic                             gam_we;
   logic                             gam_re;

   logic [8:0]                       w;
   logic [8:0]                       b;
   logic signed [17:0]               diff;
   logic signed [27:0]               wdiff;
   logic signed [27:0]               acc;
   logic [19:0]                      sm_raw;
   logic [15:0]                      sm_level;
   logic [15:0]                      new_level;
   logic [15:0]                      idx_sum;
   logic [lcsg_pkg::GAM_AW-1:0]      idx;
   logic [24:0]                      prod;
   logic [25:0]                      rnd;
   logic [9:0]                       scaled;
   logic [7:0]                       out_byte;
   logic                             out_free;

   assign w = (weight_ff > lcsg_pkg::Q08_ONE) ? lcsg_pkg::Q08_ONE : weight_ff;
   assign b = (bright_ff > lcsg_pkg::Q08_ONE) ? lcsg_pkg::Q08_ONE : bright_ff;

   // level + w * (value - level), rounded
   assign diff     = $signed({2'b00, cur_ff.value, 8'h00}) - $signed({2'b00, lvl_rd_ff});
   assign wdiff    = diff * $signed({1'b0, w});
   assign acc      = $signed({4'b0000, lvl_rd_ff, 8'h00}) + wdiff + 28'sd128;
   assign sm_raw   = acc[27:8];
   assign sm_level = (sm_raw > 20'(lcsg_pkg::LEVEL_MAX)) ? lcsg_pkg::LEVEL_MAX : sm_raw[15:0];

   always_comb begin
      case (cur_ff.op)
         lcsg_pkg::OP_SMOOTH: new_level = sm_level;
         lcsg_pkg::OP_SET:    new_level = {cur_ff.value, 8'h00};
         default:             new_level = lvl_rd_ff;
      endcase
   end

   assign idx_sum = new_level + 16'd128;
   assign idx     = idx_sum[15:8];

   assign prod     = {9'b0, gam_rd_ff} * {16'b0, b};
   assign rnd      = {1'b0, prod} + 26'd32768;
   assign scaled   = rnd[25:16];
   assign out_byte = (scaled > 10'd255) ? 8'hFF : scaled[7:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && q.valid && !clear_ff;
   assign clear_busy = clear_ff;

   assign lvl_we    = clear_ff ||
                      ((state_ff == ST_UPDATE) && (cur_ff.op != lcsg_pkg::OP_READ));
   assign lvl_waddr = clear_ff ? clr_cnt_ff : cur_ff.channel[lcsg_pkg::LVL_AW-1:0];
   assign lvl_wdata = clear_ff ? 16'h0000 : new_level;
   assign gam_we    = pop && (q.cmd.op == lcsg_pkg::OP_GAMMA);
   assign gam_re    = (state_ff == ST_UPDATE);

   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      clr_cnt_in     = clr_cnt_ff;
      cur_in         = cur_ff;
      weight_in      = weight_ff;
      bright_in      = bright_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_channel_in = rsp_channel_ff;
      rsp_level_in   = rsp_level_ff;

      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == lcsg_pkg::LAST_CHANNEL) begin
            clear_in = 1'b0;
         end
      end

      if (csr_we) begin
         unique case (lcsg_pkg::csr_index_type'(csr_index))
            lcsg_pkg::CSR_WEIGHT: weight_in = csr_wdata;
            lcsg_pkg::CSR_BRIGHT: bright_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_in = q.cmd;
               if (q.cmd.op != lcsg_pkg::OP_GAMMA) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = cur_ff.channel;
               rsp_level_in   = out_byte;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         weight_ff    <= lcsg_pkg::WEIGHT_RESET;
         bright_ff    <= lcsg_pkg::BRIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         clr_cnt_ff     <= clr_cnt_in;
         weight_ff      <= weight_in;
         bright_ff      <= bright_in;
         rsp_valid_ff   <= rsp_valid_in;
         cur_ff         <= cur_in;
         rsp_channel_ff <= rsp_channel_in;
         rsp_level_ff   <= rsp_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_rd_ff <= lvl_mem[q.cmd.channel[lcsg_pkg::LVL_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (gam_we) begin
         gam_mem[q.cmd.lut_address] <= q.cmd.lut_word;
      end
      if (gam_re) begin
         gam_rd_ff <= gam_mem[idx];
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_level   = rsp_level_ff;

endmodule

// ===== sv/led_color_smooth_gamma.sv =====
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   req_tdata  (op, channel, value, lut_address, lut_word)
// rsp      out  rsp_tvalid/rsp_tready   rsp_tdata  (out_channel, level)
// csr      in   csr_we                  csr_index, csr_wdata
//
// Ops 0 to 2 pass through the back end in order: level store read, smoothing update with
// write-back and gamma read, then brightness multiply into the output register.
// Gamma loads write the table on pop. Rate is bound by the single-item back end sequencer.
// After reset a clearing pass zeroes the level store while req_tready is held low.
// A two-item queue lets requests be taken while a result waits on rsp_tready.
// Depends on lcsg_pkg, lcsg_front, lcsg_back.
module led_color_smooth_gamma (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // op[1:0], channel[11:2], value[19:12], lut_address[27:20], lut_word[43:28]
   input  logic [lcsg_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_channel[9:0], level[17:10]
   output logic [lcsg_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [lcsg_pkg::CSR_AW-1:0]   csr_index,
   input  logic [lcsg_pkg::CSR_DW-1:0]   csr_wdata
);

   lcsg_pkg::queue_type             q;
   logic                            pop;
   logic                            clear_busy;
   logic [lcsg_pkg::CHAN_W-1:0]     rsp_channel;
   logic [7:0]                      rsp_level;

   lcsg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clear_busy (clear_busy),
      .pop        (pop),
      .q          (q)
   );

   lcsg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q           (q),
      .pop         (pop),
      .clear_busy  (clear_busy),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_channel (rsp_channel),
      .rsp_level   (rsp_level)
   );

   assign rsp_tdata = {6'b000000, rsp_level, rsp_channel};

endmodule

// ===== sv/lcsg_checker.sv =====
// Port-level checks on led_color_smooth_gamma, attached by bind.
// Depends on lcsg_pkg and led_color_smooth_gamma_defines.svh.
`include "led_color_smooth_gamma_defines.svh"

module lcsg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lcsg_pkg::RSP_W-1:0]    rsp_tdata
);

   `LCSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `LCSG_ASSERT_NOW(a_clear_blocks, clock, reset, $past(reset), !req_tready)
   `LCSG_ASSERT_NOW(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid)
   `LCSG_ASSERT_NOW(a_rsp_channel_range, clock, reset, rsp_tvalid, rsp_tdata[9:0] < lcsg_pkg::CHANNEL_COUNT)
   `LCSG_ASSERT_NOW(a_rsp_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[23:18] == 6'b000000)

endmodule

bind led_color_smooth_gamma lcsg_checker u_lcsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
